// ===== src/rga_partial_pressure_scaler_macros.svh =====
// Assertion macros used by the partial pressure scaler checker.
`ifndef RGA_PARTIAL_PRESSURE_SCALER_MACROS_SVH
`define RGA_PARTIAL_PRESSURE_SCALER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RPPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpps check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define RPPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpps check failed");

`endif

// ===== src/rpps_pkg.sv =====
// Package with widths, codes, the gas factor table and the divider cell word type.
`timescale 1ns / 1ps
package rpps_pkg;

  localparam int CURRENT_WIDTH = 32;
  localparam int FRAC_BITS = 16;

  localparam int MASS_W = 8;
  localparam int CFG_W = 32;
  localparam int SENS_W = 32;
  localparam int GAIN_W = 24;
  localparam int UNIT_W = 2;
  localparam int IDX_W = 2;
  localparam int ST_W = 2;
  localparam int FRAG_W = 7;
  localparam int ION_W = 10;
  localparam int U4_W = 21;
  localparam int FX_W = 21;
  localparam int Q_W = 48;
  localparam int CM_W = CURRENT_WIDTH + MASS_W;
  localparam int N_W = CM_W + U4_W;
  localparam int SH_W = 24 + FRAC_BITS;
  localparam int NUM_W = N_W + SH_W;
  localparam int TOP_W = NUM_W - Q_W;
  localparam int GS_W = GAIN_W + SENS_W;
  localparam int SPLIT_W = 28;
  localparam int PART_W = FX_W + SPLIT_W;
  localparam int DEN_W = FX_W + GS_W;
  localparam int REM_W = DEN_W + 1;

  localparam logic [IDX_W-1:0] REG_SENS = 2'd0;
  localparam logic [IDX_W-1:0] REG_EM_EN = 2'd1;
  localparam logic [IDX_W-1:0] REG_EM_GAIN = 2'd2;
  localparam logic [IDX_W-1:0] REG_UNIT = 2'd3;

  localparam logic [UNIT_W-1:0] UNIT_MBAR = 2'd1;
  localparam logic [UNIT_W-1:0] UNIT_PA = 2'd2;

  localparam logic [U4_W-1:0] U4_TORR = 21'd10000;
  localparam logic [U4_W-1:0] U4_MBAR = 21'd13332;
  localparam logic [U4_W-1:0] U4_PA = 21'd1333200;

  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_MASS_ZERO = 2'd1;
  localparam logic [ST_W-1:0] ST_CUR_ZERO = 2'd2;
  localparam logic [ST_W-1:0] ST_SAT = 2'd3;

  localparam logic [Q_W-1:0] OUT_MAX = {Q_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_ONE = 24'd256;
  localparam logic [SENS_W-1:0] SENS_RESET = 32'd65536;

  localparam int NUM_GASES = 17;
  localparam logic [MASS_W-1:0] GAS_MASS [NUM_GASES] = '{
    8'd2, 8'd4, 8'd16, 8'd18, 8'd20, 8'd28, 8'd31, 8'd32, 8'd34,
    8'd40, 8'd41, 8'd43, 8'd44, 8'd78, 8'd84, 8'd85, 8'd91};
  localparam logic [FRAG_W-1:0] GAS_FRAG [NUM_GASES] = '{
    7'd98, 7'd100, 7'd46, 7'd75, 7'd90, 7'd94, 7'd49, 7'd95, 7'd52,
    7'd88, 7'd21, 7'd58, 7'd85, 7'd53, 7'd45, 7'd62, 7'd53};
  localparam logic [ION_W-1:0] GAS_ION [NUM_GASES] = '{
    10'd44, 10'd14, 10'd160, 10'd100, 10'd23, 10'd100, 10'd360, 10'd100, 10'd220,
    10'd120, 10'd660, 10'd360, 10'd140, 10'd590, 10'd170, 10'd270, 10'd680};

  typedef struct packed {
    logic [FRAG_W-1:0] frag;
    logic [ION_W-1:0] ion;
  } gas_factors_t;

  typedef struct packed {
    logic valid;
    logic [ST_W-1:0] st;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0] low;
    logic [Q_W-1:0] quo;
  } cell_t;

  // Masses not in the table use unity factors, i.e. one hundred hundredths.
  function automatic gas_factors_t gas_lookup(input logic [MASS_W-1:0] m);
    gas_factors_t r;
    r.frag = 7'd100;
    r.ion = 10'd100;
    for (int i = 0; i < NUM_GASES; i++) begin
      if (GAS_MASS[i] == m) begin
        r.frag = GAS_FRAG[i];
        r.ion = GAS_ION[i];
      end
    end
    return r;
  endfunction

endpackage

// ===== src/rpps_prep.sv =====
// Front stages: factor lookup, numerator and denominator products, overflow test.
`timescale 1ns / 1ps
module rpps_prep import rpps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  logic [MASS_W-1:0] mass_number,
  input  logic [CURRENT_WIDTH-1:0] ion_current,
  input  logic [SENS_W-1:0] sensitivity,
  input  logic em_enable,
  input  logic [GAIN_W-1:0] em_gain,
  input  logic [UNIT_W-1:0] pressure_unit,
  output cell_t dout
);

  logic a_valid, b_valid, c_valid;
  logic [ST_W-1:0] a_st, b_st, c_st;
  logic [CM_W-1:0] a_cm;
  logic [U4_W-1:0] a_u4;
  logic [FX_W-1:0] a_fx;
  logic [GS_W-1:0] a_gs;
  logic [N_W-1:0] b_n, c_n;
  logic [PART_W-1:0] b_den_lo, b_den_hi;
  logic [DEN_W-1:0] c_den;

  gas_factors_t gf;
  logic [GAIN_W-1:0] g_sel;
  logic [U4_W-1:0] u4_sel;
  logic [ST_W-1:0] st_sel;
  logic [NUM_W-1:0] num;
  logic [TOP_W-1:0] top;
  logic ovf;
  cell_t dout_next;

  always_comb begin
    gf = gas_lookup(mass_number);
    g_sel = em_enable ? em_gain : GAIN_ONE;
    case (pressure_unit)
      UNIT_MBAR: u4_sel = U4_MBAR;
      UNIT_PA:   u4_sel = U4_PA;
      default:   u4_sel = U4_TORR;
    endcase
    if (mass_number == '0) begin
      st_sel = ST_MASS_ZERO;
    end else if (ion_current == '0) begin
      st_sel = ST_CUR_ZERO;
    end else if (sensitivity == '0 || g_sel == '0) begin
      st_sel = ST_SAT;
    end else begin
      st_sel = ST_OK;
    end
  end

  always_comb begin
    num = {c_n, {SH_W{1'b0}}};
    top = num[NUM_W-1:Q_W];
    ovf = {{(DEN_W-TOP_W){1'b0}}, top} >= c_den;
    dout_next.valid = c_valid;
    dout_next.st = (c_st == ST_OK && ovf) ? ST_SAT : c_st;
    dout_next.den = c_den;
    dout_next.rem = {{(DEN_W-TOP_W){1'b0}}, top};
    dout_next.low = num[Q_W-1:0];
    dout_next.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  // The denominator product is split in two halves of the gain-sensitivity term.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_st <= st_sel;
      a_cm <= CM_W'(ion_current) * CM_W'(mass_number);
      a_u4 <= u4_sel;
      a_fx <= FX_W'(28) * FX_W'(gf.frag) * FX_W'(gf.ion);
      a_gs <= GS_W'(g_sel) * GS_W'(sensitivity);
      b_st <= a_st;
      b_n <= N_W'(a_cm) * N_W'(a_u4);
      b_den_lo <= PART_W'(a_fx) * PART_W'(a_gs[SPLIT_W-1:0]);
      b_den_hi <= PART_W'(a_fx) * PART_W'(a_gs[GS_W-1:SPLIT_W]);
      c_st <= b_st;
      c_n <= b_n;
      c_den <= DEN_W'(b_den_lo) + (DEN_W'(b_den_hi) << SPLIT_W);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout <= dout_next;
    end
  end

endmodule

// ===== src/rpps_div_cell.sv =====
// One restoring division cell: develops one quotient bit and passes the word on.
`timescale 1ns / 1ps
module rpps_div_cell import rpps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  cell_t din,
  output cell_t dout
);

  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] diff;
  logic take;
  cell_t dout_next;

  always_comb begin
    trial = {din.rem, din.low[Q_W-1]};
    diff = trial - {1'b0, din.den};
    take = trial >= {1'b0, din.den};
    dout_next.valid = din.valid;
    dout_next.st = din.st;
    dout_next.den = din.den;
    dout_next.rem = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    dout_next.low = {din.low[Q_W-2:0], 1'b0};
    dout_next.quo = {din.quo[Q_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout <= dout_next;
    end
  end

endmodule

// ===== src/rga_partial_pressure_scaler.sv =====
// Top level of the residual gas analyzer partial pressure scaler.
// The input channel takes one word per cycle while in_stall is low: a mass number and an ion current.
// The output channel gives one word per input word, in order: the partial
// pressure in unsigned Q32.16 of the selected unit and a status code.
// Registers are written through wr_en, wr_index and wr_data; the user must write them only while idle (not enforced).
// From input acceptance to output valid, a word passes four front
// stages for lookup and products, 48 division cells (one quotient bit each)
// and the output register. Throughput is one word per cycle while the output is not stalled.
// The whole pipeline moves as one; a stalled output freezes every stage and
// raises in_stall, and the output word holds until it is taken.
// Reset empties the pipeline and loads the register defaults: sensitivity
// 1.0, gain off, gain 1.0, Torr.
`timescale 1ns / 1ps
module rga_partial_pressure_scaler import rpps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [MASS_W-1:0] mass_number,
  input  logic [CURRENT_WIDTH-1:0] ion_current,
  output logic out_valid,
  input  logic out_stall,
  output logic [Q_W-1:0] partial_pressure,
  output logic [ST_W-1:0] status,
  input  logic wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0] wr_data
);

  logic [SENS_W-1:0] sensitivity;
  logic em_enable;
  logic [GAIN_W-1:0] em_gain;
  logic [UNIT_W-1:0] pressure_unit;
  logic adv;
  cell_t chain [Q_W+1];
  cell_t last;

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign last = chain[Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity <= SENS_RESET;
      em_enable <= 1'b0;
      em_gain <= GAIN_ONE;
      pressure_unit <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_SENS:    sensitivity <= wr_data[SENS_W-1:0];
        REG_EM_EN:   em_enable <= wr_data[0];
        REG_EM_GAIN: em_gain <= wr_data[GAIN_W-1:0];
        REG_UNIT:    pressure_unit <= wr_data[UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  rpps_prep u_prep (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_valid(in_valid),
    .mass_number(mass_number),
    .ion_current(ion_current),
    .sensitivity(sensitivity),
    .em_enable(em_enable),
    .em_gain(em_gain),
    .pressure_unit(pressure_unit),
    .dout(chain[0])
  );

  for (genvar i = 0; i < Q_W; i++) begin : g_cell
    rpps_div_cell u_cell (
      .clk(clk),
      .rst(rst),
      .adv(adv),
      .din(chain[i]),
      .dout(chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status <= last.st;
      case (last.st)
        ST_OK:   partial_pressure <= last.quo;
        ST_SAT:  partial_pressure <= OUT_MAX;
        default: partial_pressure <= '0;
      endcase
    end
  end

endmodule

// ===== src/rpps_checker.sv =====
// Port-level checker for the partial pressure scaler and its bind.
`timescale 1ns / 1ps
`include "rga_partial_pressure_scaler_macros.svh"
module rpps_checker import rpps_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [Q_W-1:0] partial_pressure,
  input logic [ST_W-1:0] status
);

  `RPPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(partial_pressure) && $stable(status))
  `RPPS_ASSERT_NOW(a_stall_follows_out, 1'b1, in_stall == (out_valid && out_stall))
  `RPPS_ASSERT_NOW(a_zero_codes, out_valid && (status == ST_MASS_ZERO || status == ST_CUR_ZERO), partial_pressure == '0)
  `RPPS_ASSERT_NOW(a_sat_value, out_valid && status == ST_SAT, partial_pressure == OUT_MAX)

endmodule

bind rga_partial_pressure_scaler rpps_checker u_rpps_checker (.*);
